@@ hw/rtl/queue_delay_statistics_monitor_assert.svh @@
// ---------------------------------------------------------------------------
// queue delay statistics monitor - assertion macros
// shared wrappers for the clocked checks in the monitor rtl
// ---------------------------------------------------------------------------
`ifndef QUEUE_DELAY_STATISTICS_MONITOR_ASSERT_SVH
`define QUEUE_DELAY_STATISTICS_MONITOR_ASSERT_SVH

// same-cycle implication, masked while reset is held
`define QDSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is held
`define QDSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/qdsm_pkg.sv @@
// ---------------------------------------------------------------------------
// qdsm_pkg
// constants, types and helper functions of the queue delay statistics monitor
// ---------------------------------------------------------------------------
`default_nettype none

package qdsm_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int TIME_BITS   = 32;

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int SUM_W  = 48;
    localparam int STAT_W = 32;
    localparam int PROD_W = CNT_W + TIME_BITS;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 32'd1;

    // register index taken from paddr above the byte offset
    localparam logic [CFG_ADDR_W-3:0] REG_DELAY_THRESHOLD = 1'b0;

    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_DEPART  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DROP     = 2'd1,
        ST_IDLE_DEP = 2'd2
    } t_status;

    function automatic logic [TIME_BITS-1:0] elapsed(
        input logic [TIME_BITS-1:0] now,
        input logic [TIME_BITS-1:0] then_t
    );
        return (now >= then_t) ? (now - then_t) : '0;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add48(
        input logic [SUM_W-1:0] a,
        input logic [63:0]      b
    );
        logic [SUM_W:0] sum;
        sum = {1'b0, a} + {1'b0, b[SUM_W-1:0]};
        if ((b[63:SUM_W] != '0) || sum[SUM_W]) begin
            return SUM_MAX;
        end
        return sum[SUM_W-1:0];
    endfunction

    function automatic logic [STAT_W-1:0] sat_inc32(input logic [STAT_W-1:0] a);
        return (a == STAT_MAX) ? a : a + 1'b1;
    endfunction

    function automatic logic [STAT_W-1:0] peak32(
        input logic [STAT_W-1:0]    peak,
        input logic [TIME_BITS-1:0] v
    );
        logic [SUM_W-1:0]  wide;
        logic [STAT_W-1:0] c;
        wide = SUM_W'(v);
        c = (wide > SUM_W'(STAT_MAX)) ? STAT_MAX : wide[STAT_W-1:0];
        return (c > peak) ? c : peak;
    endfunction

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qdsm_ram.sv @@
// ---------------------------------------------------------------------------
// qdsm_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module qdsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/queue_delay_statistics_monitor.sv @@
// ---------------------------------------------------------------------------
// queue_delay_statistics_monitor
// statistics of a single-server fifo queue from a stream of arrival and
// departure events
// ---------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one event per beat: i_action
//   (arrival or departure) and its tick time i_event_time. Output channel
//   o_valid/i_ready carries one result beat per event: status, queue state
//   and all running statistics after that event.
//   An input beat passes first through the input register, where the elapsed
//   time is formed, and then through the statistics update, which loads the
//   result register that drives the result beat.
//   Throughput is one event per cycle while the receiver keeps up; the next
//   departure's ring read is issued ahead from the waiting-time ram.
//   The delay threshold is written over the apb port (byte address 0) while
//   no event is in flight; pready is always high.
//   Reset (synchronous, active low) empties the queue, idles the server,
//   clears every statistic and sets the threshold to 1. The ram needs no
//   clearing pass since only written entries are ever read.
//   When the receiver stalls, the result beat holds and one further event
//   is taken into the input register; then o_ready drops until a beat leaves.
// ---------------------------------------------------------------------------
`default_nettype none

`include "queue_delay_statistics_monitor_assert.svh"

module queue_delay_statistics_monitor (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // event channel
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic                                   i_action,
    input  wire logic [31:0]                            i_event_time,
    // result channel
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output qdsm_pkg::t_status                           o_status,
    output logic [7:0]                                  o_queue_length,
    output logic                                        o_server_busy,
    output logic [31:0]                                 o_customers_delayed,
    output logic [47:0]                                 o_total_delay,
    output logic [31:0]                                 o_peak_delay,
    output logic [31:0]                                 o_excess_count,
    output logic [7:0]                                  o_peak_queue,
    output logic [47:0]                                 o_area_in_queue,
    output logic [47:0]                                 o_area_busy,
    output logic [47:0]                                 o_total_system_time,
    output logic [31:0]                                 o_max_system_time,
    // configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [qdsm_pkg::CFG_ADDR_W-1:0]        paddr,
    input  wire logic [qdsm_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic      [qdsm_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                        pready
);

    import qdsm_pkg::*;

    // configuration
    logic [CFG_DATA_W-1:0] r_threshold;
    logic                  cfg_hit;

    // input stage
    logic                 r_in_valid;
    logic                 r_in_action;
    logic [TIME_BITS-1:0] r_in_time;
    logic [TIME_BITS-1:0] r_in_dt;
    logic [TIME_BITS-1:0] r_last_time;
    logic [TIME_BITS-1:0] now_in;
    logic                 in_fire;
    logic                 upd_fire;

    // queue state
    logic                 r_out_valid;
    t_status              r_status,  n_status;
    logic                 r_busy,    n_busy;
    logic [CNT_W-1:0]     r_count,   n_count;
    logic [PTR_W-1:0]     r_head,    n_head;
    logic [PTR_W-1:0]     r_tail,    n_tail;
    logic [TIME_BITS-1:0] r_serving, n_serving;

    // statistics
    logic [STAT_W-1:0]    r_delayed, n_delayed;
    logic [SUM_W-1:0]     r_dsum,    n_dsum;
    logic [STAT_W-1:0]    r_dpeak,   n_dpeak;
    logic [STAT_W-1:0]    r_excess,  n_excess;
    logic [CNT_W-1:0]     r_qpeak,   n_qpeak;
    logic [SUM_W-1:0]     r_qarea,   n_qarea;
    logic [SUM_W-1:0]     r_barea,   n_barea;
    logic [SUM_W-1:0]     r_ssum,    n_ssum;
    logic [STAT_W-1:0]    r_speak,   n_speak;

    // ring fifo of waiting arrival times
    logic                 ram_we;
    logic [TIME_BITS-1:0] ram_rdata;
    logic                 r_fwd;
    logic [TIME_BITS-1:0] r_fwd_data;
    logic [TIME_BITS-1:0] head_time;

    logic [PROD_W-1:0]    area_prod;
    logic                 note_en;
    logic [TIME_BITS-1:0] note_delay;
    logic [TIME_BITS-1:0] stay;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_DELAY_THRESHOLD);
    assign prdata  = cfg_hit ? r_threshold : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_threshold <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign upd_fire = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || upd_fire;
    assign in_fire  = i_valid && o_ready;
    assign o_valid  = r_out_valid;

    assign now_in = TIME_BITS'(i_event_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_time <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid  <= 1'b1;
                r_last_time <= now_in;
            end else if (upd_fire) begin
                r_in_valid <= 1'b0;
            end
            if (upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // elapsed time is taken against the previous beat's time at the input
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_action <= i_action;
            r_in_time   <= now_in;
            r_in_dt     <= elapsed(now_in, r_last_time);
        end
    end

    // ------------------------------------------------------------------
    // ring ram, read ahead at the next head
    // ------------------------------------------------------------------
    qdsm_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_tail),
        .i_wr_data (r_in_time),
        .i_rd_addr (n_head),
        .o_rd_data (ram_rdata)
    );

    // write into an empty queue lands on the head being read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= ram_we && (r_tail == n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= r_in_time;
    end

    assign head_time = r_fwd ? r_fwd_data : ram_rdata;

    // ------------------------------------------------------------------
    // event update
    // ------------------------------------------------------------------
    assign area_prod = PROD_W'(r_count) * PROD_W'(r_in_dt);

    always_comb begin
        n_status   = ST_OK;
        n_busy     = r_busy;
        n_count    = r_count;
        n_head     = r_head;
        n_tail     = r_tail;
        n_serving  = r_serving;
        n_qpeak    = r_qpeak;
        n_ssum     = r_ssum;
        n_speak    = r_speak;
        ram_we     = 1'b0;
        note_en    = 1'b0;
        note_delay = '0;
        stay       = elapsed(r_in_time, r_serving);

        n_qarea = sat_add48(r_qarea, 64'(area_prod));
        n_barea = r_busy ? sat_add48(r_barea, 64'(r_in_dt)) : r_barea;

        if (r_in_action == ACT_ARRIVAL) begin
            if (!r_busy) begin
                // straight into service with no queue delay
                n_busy    = 1'b1;
                n_serving = r_in_time;
                note_en   = 1'b1;
            end else if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                n_status = ST_DROP;
            end else begin
                ram_we  = upd_fire;
                n_tail  = ring_next(r_tail);
                n_count = r_count + 1'b1;
                if (n_count > r_qpeak) begin
                    n_qpeak = n_count;
                end
            end
        end else begin
            if (!r_busy) begin
                n_status = ST_IDLE_DEP;
            end else begin
                n_ssum  = sat_add48(r_ssum, 64'(stay));
                n_speak = peak32(r_speak, stay);
                if (r_count == '0) begin
                    n_busy = 1'b0;
                end else begin
                    n_head     = ring_next(r_head);
                    n_count    = r_count - 1'b1;
                    n_serving  = head_time;
                    note_en    = 1'b1;
                    note_delay = elapsed(r_in_time, head_time);
                end
            end
        end

        if (!upd_fire) begin
            n_head = r_head;
        end

        n_delayed = note_en ? sat_inc32(r_delayed) : r_delayed;
        n_dsum    = note_en ? sat_add48(r_dsum, 64'(note_delay)) : r_dsum;
        n_dpeak   = note_en ? peak32(r_dpeak, note_delay) : r_dpeak;
        n_excess  = (note_en && (SUM_W'(note_delay) > SUM_W'(r_threshold)))
                    ? sat_inc32(r_excess) : r_excess;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= ST_OK;
            r_busy    <= 1'b0;
            r_count   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_delayed <= '0;
            r_dsum    <= '0;
            r_dpeak   <= '0;
            r_excess  <= '0;
            r_qpeak   <= '0;
            r_qarea   <= '0;
            r_barea   <= '0;
            r_ssum    <= '0;
            r_speak   <= '0;
        end else if (upd_fire) begin
            r_status  <= n_status;
            r_busy    <= n_busy;
            r_count   <= n_count;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_delayed <= n_delayed;
            r_dsum    <= n_dsum;
            r_dpeak   <= n_dpeak;
            r_excess  <= n_excess;
            r_qpeak   <= n_qpeak;
            r_qarea   <= n_qarea;
            r_barea   <= n_barea;
            r_ssum    <= n_ssum;
            r_speak   <= n_speak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_serving <= n_serving;
        end
    end

    // state only moves when a new result is loaded, so it is the result
    assign o_status            = r_status;
    assign o_queue_length      = 8'(r_count);
    assign o_server_busy       = r_busy;
    assign o_customers_delayed = r_delayed;
    assign o_total_delay       = r_dsum;
    assign o_peak_delay        = r_dpeak;
    assign o_excess_count      = r_excess;
    assign o_peak_queue        = 8'(r_qpeak);
    assign o_area_in_queue     = r_qarea;
    assign o_area_busy         = r_barea;
    assign o_total_system_time = r_ssum;
    assign o_max_system_time   = r_speak;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `QDSM_ASSERT_NOW(a_idle_empty, i_clk, i_rst_n, !r_busy, r_count == '0,
        "customers waiting while the server is idle")
    `QDSM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(QUEUE_DEPTH) && r_qpeak <= CNT_W'(QUEUE_DEPTH),
        "queue count beyond ring depth")
    `QDSM_ASSERT_NOW(a_drop_full, i_clk, i_rst_n, r_out_valid && r_status == ST_DROP,
        r_busy && r_count == CNT_W'(QUEUE_DEPTH), "arrival dropped on a queue not full")
    `QDSM_ASSERT_NOW(a_idle_dep, i_clk, i_rst_n, r_out_valid && r_status == ST_IDLE_DEP,
        !r_busy, "idle departure reported with a customer in service")
    `QDSM_ASSERT_NEXT(a_peak_track, i_clk, i_rst_n, upd_fire,
        r_qpeak >= r_count, "queue peak below current queue length")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench - queue delay statistics monitor
// drives arrival and departure events into the monitor, predicts every
// result beat from its own model of the queue and compares each field;
// the delay threshold is reprogrammed over apb between phases
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import qdsm_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] THRESHOLD_ADDR = {REG_DELAY_THRESHOLD, 2'b00};
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_EVENTS = 140;

    typedef struct {
        t_status     status;
        logic [7:0]  queue_length;
        logic        server_busy;
        logic [31:0] customers_delayed;
        logic [47:0] total_delay;
        logic [31:0] peak_delay;
        logic [31:0] excess_count;
        logic [7:0]  peak_queue;
        logic [47:0] area_in_queue;
        logic [47:0] area_busy;
        logic [47:0] total_system_time;
        logic [31:0] max_system_time;
    } t_queue_stats;

    class queue_stats_scoreboard;
        logic [31:0]  threshold;
        bit           busy;
        int           waiting;
        logic [31:0]  arrivals [QUEUE_DEPTH];
        int           head;
        int           tail;
        logic [31:0]  serving_since;
        logic [31:0]  last_tick;
        logic [31:0]  n_delayed;
        logic [47:0]  delay_sum;
        logic [31:0]  delay_peak;
        logic [31:0]  n_excess;
        int           queue_peak;
        logic [47:0]  queue_area;
        logic [47:0]  busy_area;
        logic [47:0]  stay_sum;
        logic [31:0]  stay_peak;
        t_queue_stats expected_stats [$];
        int           errors;

        function new();
            threshold = THRESHOLD_RESET;
            busy = 1'b0;
            waiting = 0;
            head = 0;
            tail = 0;
            serving_since = '0;
            last_tick = '0;
            n_delayed = '0;
            delay_sum = '0;
            delay_peak = '0;
            n_excess = '0;
            queue_peak = 0;
            queue_area = '0;
            busy_area = '0;
            stay_sum = '0;
            stay_peak = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        // ticks from then_tick to at_tick, zero when time went back
        function logic [31:0] span(logic [31:0] at_tick, logic [31:0] then_tick);
            return (at_tick >= then_tick) ? at_tick - then_tick : '0;
        endfunction

        function logic [47:0] add_sat(logic [47:0] a, logic [63:0] b);
            logic [64:0] s;
            s = 65'(a) + 65'(b);
            return (s > 65'(SUM_MAX)) ? SUM_MAX : s[47:0];
        endfunction

        function void count_delay(logic [31:0] d);
            n_delayed = (n_delayed == STAT_MAX) ? n_delayed : n_delayed + 1;
            delay_sum = add_sat(delay_sum, 64'(d));
            if (d > delay_peak) delay_peak = d;
            if (d > threshold) n_excess = (n_excess == STAT_MAX) ? n_excess : n_excess + 1;
        endfunction

        function void note_event(logic act, logic [31:0] at_tick);
            t_queue_stats e;
            logic [31:0]  dt;
            logic [31:0]  stay;
            dt = span(at_tick, last_tick);
            last_tick = at_tick;
            queue_area = add_sat(queue_area, 64'(waiting) * 64'(dt));
            if (busy) busy_area = add_sat(busy_area, 64'(dt));
            e.status = ST_OK;
            if (act == ACT_ARRIVAL) begin
                if (!busy) begin
                    busy = 1'b1;
                    serving_since = at_tick;
                    count_delay('0);
                end else if (waiting >= QUEUE_DEPTH) begin
                    e.status = ST_DROP;
                end else begin
                    arrivals[tail] = at_tick;
                    tail = (tail + 1) % QUEUE_DEPTH;
                    waiting++;
                    if (waiting > queue_peak) queue_peak = waiting;
                end
            end else if (!busy) begin
                e.status = ST_IDLE_DEP;
            end else begin
                stay = span(at_tick, serving_since);
                stay_sum = add_sat(stay_sum, 64'(stay));
                if (stay > stay_peak) stay_peak = stay;
                if (waiting == 0) begin
                    busy = 1'b0;
                end else begin
                    serving_since = arrivals[head];
                    head = (head + 1) % QUEUE_DEPTH;
                    waiting--;
                    count_delay(span(at_tick, serving_since));
                end
            end
            e.queue_length      = 8'(waiting);
            e.server_busy       = busy;
            e.customers_delayed = n_delayed;
            e.total_delay       = delay_sum;
            e.peak_delay        = delay_peak;
            e.excess_count      = n_excess;
            e.peak_queue        = 8'(queue_peak);
            e.area_in_queue     = queue_area;
            e.area_busy         = busy_area;
            e.total_system_time = stay_sum;
            e.max_system_time   = stay_peak;
            expected_stats.push_back(e);
        endfunction

        function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
                errors++;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_result(t_queue_stats got);
            t_queue_stats want;
            bit           ok;
            if (expected_stats.size() == 0) begin
                $display("%0t result beat with nothing expected: status %0d", $time,
                         got.status);
                errors++;
                return;
            end
            want = expected_stats.pop_front();
            ok = field_ok("status", 64'(want.status), 64'(got.status));
            ok &= field_ok("queue_length", 64'(want.queue_length), 64'(got.queue_length));
            ok &= field_ok("server_busy", 64'(want.server_busy), 64'(got.server_busy));
            ok &= field_ok("customers_delayed", 64'(want.customers_delayed),
                           64'(got.customers_delayed));
            ok &= field_ok("total_delay", 64'(want.total_delay), 64'(got.total_delay));
            ok &= field_ok("peak_delay", 64'(want.peak_delay), 64'(got.peak_delay));
            ok &= field_ok("excess_count", 64'(want.excess_count), 64'(got.excess_count));
            ok &= field_ok("peak_queue", 64'(want.peak_queue), 64'(got.peak_queue));
            ok &= field_ok("area_in_queue", 64'(want.area_in_queue), 64'(got.area_in_queue));
            ok &= field_ok("area_busy", 64'(want.area_busy), 64'(got.area_busy));
            ok &= field_ok("total_system_time", 64'(want.total_system_time),
                           64'(got.total_system_time));
            ok &= field_ok("max_system_time", 64'(want.max_system_time),
                           64'(got.max_system_time));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic                  i_action     = ACT_ARRIVAL;
    logic [31:0]           i_event_time = '0;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    t_status               o_status;
    logic [7:0]            o_queue_length;
    logic                  o_server_busy;
    logic [31:0]           o_customers_delayed;
    logic [47:0]           o_total_delay;
    logic [31:0]           o_peak_delay;
    logic [31:0]           o_excess_count;
    logic [7:0]            o_peak_queue;
    logic [47:0]           o_area_in_queue;
    logic [47:0]           o_area_busy;
    logic [47:0]           o_total_system_time;
    logic [31:0]           o_max_system_time;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    queue_stats_scoreboard stats_sb;
    bit                    src_idle    = 1'b0;
    bit                    sink_idle   = 1'b0;
    int                    stall_left  = 0;
    int                    quiet_count = 0;
    int                    events_sent = 0;
    logic [31:0]           tick        = '0;

    queue_delay_statistics_monitor i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_action            (i_action),
        .i_event_time        (i_event_time),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_queue_length      (o_queue_length),
        .o_server_busy       (o_server_busy),
        .o_customers_delayed (o_customers_delayed),
        .o_total_delay       (o_total_delay),
        .o_peak_delay        (o_peak_delay),
        .o_excess_count      (o_excess_count),
        .o_peak_queue        (o_peak_queue),
        .o_area_in_queue     (o_area_in_queue),
        .o_area_busy         (o_area_busy),
        .o_total_system_time (o_total_system_time),
        .o_max_system_time   (o_max_system_time),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) stall_left--;
        else if (sink_idle && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
        i_ready <= (stall_left == 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            stats_sb.check_result('{status: o_status, queue_length: o_queue_length,
                server_busy: o_server_busy, customers_delayed: o_customers_delayed,
                total_delay: o_total_delay, peak_delay: o_peak_delay,
                excess_count: o_excess_count, peak_queue: o_peak_queue,
                area_in_queue: o_area_in_queue, area_busy: o_area_busy,
                total_system_time: o_total_system_time,
                max_system_time: o_max_system_time});
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // mostly small forward steps, now and then a long jump, a step back or a wild value
    function automatic logic [31:0] next_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)      tick = tick + $urandom_range(0, 3);
        else if (r < 90) tick = tick + $urandom_range(4, 2000);
        else if (r < 95) tick = tick - $urandom_range(1, 50);
        else             tick = $urandom();
        return tick;
    endfunction

    task automatic send_event(logic act, logic [31:0] at_tick);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_event_time <= at_tick;
        do @(posedge i_clk); while (!o_ready);
        stats_sb.note_event(act, at_tick);
        events_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (stats_sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        stats_sb.threshold = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            $display("%0t mismatch delay_threshold: expected %0h actual %0h", $time, value,
                     prdata);
            stats_sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_run();
        int kind;
        int pct;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            pct = $urandom_range(30, 70);
            repeat ($urandom_range(20, 60))
                send_event(($urandom_range(0, 99) < pct) ? ACT_ARRIVAL : ACT_DEPART,
                           next_tick());
        end else if (kind < 75) begin
            // fill to the brim and push a few past it
            while (stats_sb.waiting < QUEUE_DEPTH) send_event(ACT_ARRIVAL, next_tick());
            repeat ($urandom_range(1, 3)) send_event(ACT_ARRIVAL, next_tick());
        end else if (kind < 90) begin
            while (stats_sb.busy) send_event(ACT_DEPART, next_tick());
            repeat ($urandom_range(1, 2)) send_event(ACT_DEPART, next_tick());
        end else begin
            repeat ($urandom_range(5, 15)) send_event(1'($urandom()), $urandom());
        end
    endtask

    initial begin
        logic [31:0] thresholds [5];
        int          phase_start;
        stats_sb = new();
        thresholds = '{32'd0, 32'hFFFF_FFFF, $urandom_range(2, 40), $urandom(), 32'd5};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed events under the reset threshold of one
        send_event(ACT_DEPART,  32'd0);
        send_event(ACT_ARRIVAL, 32'd0);
        send_event(ACT_ARRIVAL, 32'd0);
        send_event(ACT_ARRIVAL, 32'd3);
        send_event(ACT_DEPART,  32'd5);
        send_event(ACT_DEPART,  32'd5);
        send_event(ACT_DEPART,  32'd6);
        send_event(ACT_DEPART,  32'd6);
        send_event(ACT_ARRIVAL, 32'd7);
        send_event(ACT_ARRIVAL, 32'd8);
        send_event(ACT_DEPART,  32'd9);
        send_event(ACT_ARRIVAL, 32'd20);
        send_event(ACT_DEPART,  32'd15);
        send_event(ACT_DEPART,  32'd16);
        send_event(ACT_ARRIVAL, 32'hFFFF_FFFF);
        send_event(ACT_DEPART,  32'hFFFF_FFFF);
        send_event(ACT_DEPART,  32'hFFFF_FFFF);
        send_event(ACT_ARRIVAL, 32'd0);
        send_event(ACT_ARRIVAL, 32'h5555_5555);
        send_event(ACT_ARRIVAL, 32'hAAAA_AAAA);
        send_event(ACT_DEPART,  32'hAAAA_AAAA);
        send_event(ACT_DEPART,  32'hAAAA_AAAB);
        send_event(ACT_DEPART,  32'h8000_0000);
        drain();

        foreach (thresholds[p]) begin
            set_threshold(thresholds[p]);
            tick = $urandom_range(0, 1000);
            phase_start = events_sent;
            while (events_sent - phase_start < PHASE_EVENTS) begin
                src_idle  = (p < 4) && ($urandom_range(0, 3) != 0);
                sink_idle = (p < 4) && ($urandom_range(0, 3) != 0);
                random_run();
            end
            drain();
        end

        // drive the queue area into saturation with a full queue and wide time swings
        set_threshold(32'd0);
        while (stats_sb.waiting < QUEUE_DEPTH) send_event(ACT_ARRIVAL, 32'd0);
        repeat (520) begin
            send_event(ACT_ARRIVAL, 32'hFFFF_FFFF);
            send_event(ACT_ARRIVAL, 32'd0);
        end
        while (stats_sb.busy) send_event(ACT_DEPART, 32'hFFFF_FFFF);
        send_event(ACT_DEPART, 32'd0);
        drain();

        if (stats_sb.errors == 0 && stats_sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/qdsm_pkg.sv
hw/rtl/qdsm_ram.sv
hw/rtl/queue_delay_statistics_monitor.sv
tb/testbench.sv
